// File: rtl/core/sbfd_pkg.sv
// Shared constants and types for the SBUS frame decoder.
package sbfd_pkg;

	// Frame geometry.
	localparam int FRAME_SLOTS   = 25;
	localparam int BITS_PER_SLOT = 12;
	localparam int NUM_CHANNELS  = 16;
	localparam int CH_WIDTH      = 11;

	// Position of the parity bit inside a slot; data bits sit at 1..DATA_BITS.
	localparam int DATA_BITS  = 8;
	localparam int PARITY_POS = DATA_BITS + 1;

	localparam int SLOT_W  = $clog2(FRAME_SLOTS);
	localparam int PHASE_W = $clog2(BITS_PER_SLOT);
	localparam int CBIT_W  = $clog2(CH_WIDTH);
	localparam int CIDX_W  = 4;

	localparam logic [SLOT_W-1:0]  LAST_SLOT  = SLOT_W'(FRAME_SLOTS - 1);
	localparam logic [PHASE_W-1:0] LAST_PHASE = PHASE_W'(BITS_PER_SLOT - 1);
	localparam logic [PHASE_W-1:0] PHASE_PAR  = PHASE_W'(PARITY_POS);
	localparam logic [CBIT_W-1:0]  LAST_CBIT  = CBIT_W'(CH_WIDTH - 1);
	localparam logic [CIDX_W-1:0]  LAST_CHAN  = CIDX_W'(NUM_CHANNELS - 1);

	localparam logic [DATA_BITS-1:0] HEADER_VALUE = 8'h0F;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_RAW_CENTER = 1'b0,
		CFG_SCALE_GAIN = 1'b1
	} cfg_index_t;

	localparam logic [CH_WIDTH-1:0] RAW_CENTER_RESET = 11'd1054;
	localparam logic [15:0]         SCALE_GAIN_RESET = 16'd4989;

	// One request to the scaling pipeline.
	typedef struct packed {
		logic                     ok;
		logic [CIDX_W-1:0]        index;
		logic                     last;
		logic signed [CH_WIDTH:0] diff;
	} sbfd_scale_req_t;

endpackage

// File: rtl/core/sbfd_if.sv
// Channel interfaces: sampled line bits in, scaled channel results out.
interface sbfd_bit_if;
	logic valid;
	logic ready;
	logic frame_start;
	logic line_bit;

	modport source (output valid, output frame_start, output line_bit, input ready);
	modport sink   (input valid, input frame_start, input line_bit, output ready);
endinterface

interface sbfd_res_if;
	logic               valid;
	logic               ready;
	logic               frame_ok;
	logic [3:0]         channel_index;
	logic signed [15:0] channel_value;
	logic               last;

	modport source (output valid, output frame_ok, output channel_index,
		output channel_value, output last, input ready);
	modport sink   (input valid, input frame_ok, input channel_index,
		input channel_value, input last, output ready);
endinterface

// File: rtl/core/sbfd_scaler.sv
// Two-stage scaling pipeline: gain multiply, truncation toward zero, saturation.
module sbfd_scaler
	import sbfd_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic [15:0]     scale_gain,
	input  logic            req_valid,
	output logic            req_ready,
	input  sbfd_scale_req_t req,
	sbfd_res_if.source      result
);

	logic            s1_valid_q;
	sbfd_scale_req_t req_s1;
	logic            out_valid_q;
	logic            out_ok_q;
	logic [3:0]      out_index_q;
	logic [15:0]     out_value_q;
	logic            out_last_q;
	logic            out_adv;

	logic signed [16:0] gain_s;
	logic signed [28:0] prod;
	logic signed [28:0] biased;
	logic signed [16:0] quot;
	logic [15:0]        sat_value;

	// The whole pipe moves whenever the output register is free or being taken.
	assign out_adv   = !out_valid_q || result.ready;
	assign req_ready = !s1_valid_q || out_adv;

	// Request register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (req_ready) begin
			s1_valid_q <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1 <= req;
		end
	end

	// Multiply, round toward zero by biasing negatives, then clamp to 16 bits.
	always_comb begin
		gain_s = $signed({1'b0, scale_gain});
		prod   = 29'(req_s1.diff) * 29'(gain_s);
		biased = prod + (prod[28] ? 29'sd4095 : 29'sd0);
		quot   = biased[28:12];
		if (quot[16] != quot[15]) begin
			sat_value = quot[16] ? 16'h8000 : 16'h7FFF;
		end else begin
			sat_value = quot[15:0];
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && s1_valid_q) begin
			out_ok_q    <= req_s1.ok;
			out_index_q <= req_s1.index;
			out_value_q <= sat_value;
			out_last_q  <= req_s1.last;
		end
	end

	assign result.valid         = out_valid_q;
	assign result.frame_ok      = out_ok_q;
	assign result.channel_index = out_index_q;
	assign result.channel_value = $signed(out_value_q);
	assign result.last          = out_last_q;

endmodule

// File: rtl/core/sbus_frame_decoder_unit.sv
// SBUS frame decoder: one sampled line bit per transaction, scaled channel results out.
// The block takes one line bit per cycle while ready. A frame is 25 slots of 12 bits;
// each slot is checked for start, parity and stop bits as it arrives, and the 11-bit
// channels are assembled into a channel store. On the frame's last bit the store is
// copied into a result buffer and a sequencer issues sixteen channel results, or a
// single corrupted-frame report, one per cycle while the pipeline is ready, into a
// two-stage scaling pipeline (one multiplier) with request and result registers. Bits
// of the next frame are taken while those results drain; input is held off only when
// a frame ends while the previous frame's results are still being issued.
module sbus_frame_decoder_unit
	import sbfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [0:0]  cfg_index,
	input  logic [15:0] cfg_data,
	sbfd_bit_if.sink    sample,
	sbfd_res_if.source  result
);

	// Configuration registers.
	logic [CH_WIDTH-1:0] raw_center_q;
	logic [15:0]         scale_gain_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_center_q <= RAW_CENTER_RESET;
			scale_gain_q <= SCALE_GAIN_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index_t'(cfg_index))
				CFG_RAW_CENTER: raw_center_q <= cfg_data[CH_WIDTH-1:0];
				CFG_SCALE_GAIN: scale_gain_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame receive state.
	logic                 active_q;
	logic [SLOT_W-1:0]    slot_q;
	logic [PHASE_W-1:0]   phase_q;
	logic                 parity_q;
	logic                 bad_q;
	logic [DATA_BITS-1:0] header_q;
	logic [CH_WIDTH-1:0]  accum_q;
	logic [CBIT_W-1:0]    cbit_q;
	logic [CIDX_W-1:0]    cnum_q;
	logic                 full_q;

	logic [CH_WIDTH-1:0]  store_q [NUM_CHANNELS];
	logic [CH_WIDTH-1:0]  snap_q  [NUM_CHANNELS];

	// Result sequencer state.
	logic              drain_busy_q;
	logic              drain_bad_q;
	logic [CIDX_W-1:0] drain_idx_q;

	logic bit_acc;
	logic work;
	logic at_end;

	// Working copies after a frame start clears them.
	logic                 bit_w;
	logic [SLOT_W-1:0]    slot_w;
	logic [PHASE_W-1:0]   phase_w;
	logic                 parity_w;
	logic                 bad_w;
	logic [DATA_BITS-1:0] header_w;
	logic [CH_WIDTH-1:0]  accum_w;
	logic [CBIT_W-1:0]    cbit_w;
	logic [CIDX_W-1:0]    cnum_w;
	logic                 full_w;

	// Values after this bit.
	logic                 parity_n;
	logic                 bad_n;
	logic [DATA_BITS-1:0] header_n;
	logic [CH_WIDTH-1:0]  accum_n;
	logic [CBIT_W-1:0]    cbit_n;
	logic [CIDX_W-1:0]    cnum_n;
	logic                 full_n;
	logic                 store_we;
	logic [CH_WIDTH-1:0]  store_data;
	logic                 frame_bad_final;

	logic            req_valid;
	logic            req_ready;
	sbfd_scale_req_t req;

	// The last bit of a frame waits while the previous frame's results are issued.
	assign at_end       = active_q && slot_q == LAST_SLOT && phase_q == LAST_PHASE;
	assign sample.ready = !(drain_busy_q && at_end);
	assign bit_acc      = sample.valid && sample.ready;
	assign work         = bit_acc && (sample.frame_start || active_q);

	// Per-bit slot checks and channel assembly.
	always_comb begin
		if (sample.frame_start) begin
			bit_w    = 1'b1;
			slot_w   = '0;
			phase_w  = '0;
			parity_w = 1'b0;
			bad_w    = 1'b0;
			header_w = '0;
			accum_w  = '0;
			cbit_w   = '0;
			cnum_w   = '0;
			full_w   = 1'b0;
		end else begin
			bit_w    = sample.line_bit;
			slot_w   = slot_q;
			phase_w  = phase_q;
			parity_w = parity_q;
			bad_w    = bad_q;
			header_w = header_q;
			accum_w  = accum_q;
			cbit_w   = cbit_q;
			cnum_w   = cnum_q;
			full_w   = full_q;
		end

		parity_n   = parity_w;
		bad_n      = bad_w;
		header_n   = header_w;
		accum_n    = accum_w;
		cbit_n     = cbit_w;
		cnum_n     = cnum_w;
		full_n     = full_w;
		store_we   = 1'b0;
		store_data = accum_w;

		if (phase_w == '0) begin
			// Start bit must be high on the inverted line.
			bad_n    = bad_w | !bit_w;
			parity_n = 1'b0;
		end else if (phase_w <= PHASE_W'(DATA_BITS)) begin
			parity_n = parity_w ^ bit_w;
			if (slot_w == '0) begin
				header_n = {header_w[DATA_BITS-2:0], bit_w};
			end else if (!full_w) begin
				accum_n          = accum_w;
				accum_n[cbit_w]  = accum_w[cbit_w] | bit_w;
				if (cbit_w == LAST_CBIT) begin
					store_we   = 1'b1;
					store_data = accum_n;
					accum_n    = '0;
					cbit_n     = '0;
					cnum_n     = cnum_w + 1'b1;
					full_n     = (cnum_w == LAST_CHAN);
				end else begin
					cbit_n = cbit_w + 1'b1;
				end
			end
		end else if (phase_w == PHASE_PAR) begin
			bad_n = bad_w | (parity_w == bit_w);
		end else begin
			// Stop bits must be low.
			bad_n = bad_w | bit_w;
		end

		frame_bad_final = bad_n || (header_n != HEADER_VALUE);
	end

	// Frame state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			slot_q   <= '0;
			phase_q  <= '0;
			parity_q <= 1'b0;
			bad_q    <= 1'b0;
			header_q <= '0;
			accum_q  <= '0;
			cbit_q   <= '0;
			cnum_q   <= '0;
			full_q   <= 1'b0;
		end else if (work) begin
			parity_q <= parity_n;
			bad_q    <= bad_n;
			header_q <= header_n;
			accum_q  <= accum_n;
			cbit_q   <= cbit_n;
			cnum_q   <= cnum_n;
			full_q   <= full_n;
			if (slot_w == LAST_SLOT && phase_w == LAST_PHASE) begin
				active_q <= 1'b0;
				slot_q   <= '0;
				phase_q  <= '0;
			end else begin
				active_q <= 1'b1;
				if (phase_w == LAST_PHASE) begin
					phase_q <= '0;
					slot_q  <= slot_w + 1'b1;
				end else begin
					phase_q <= phase_w + 1'b1;
					slot_q  <= slot_w;
				end
			end
		end
	end

	// Channel store and the result buffer copied from it at frame end.
	always_ff @(posedge clk) begin
		if (work && store_we) begin
			store_q[cnum_w] <= store_data;
		end
		if (work && at_end && !sample.frame_start) begin
			snap_q <= store_q;
		end
	end

	// Result sequencer: issues one request per cycle while the scaling pipeline is ready.
	always_comb begin
		req_valid  = drain_busy_q;
		req.ok     = !drain_bad_q;
		req.index  = drain_bad_q ? '0 : drain_idx_q;
		req.last   = drain_bad_q || drain_idx_q == LAST_CHAN;
		req.diff   = drain_bad_q ? '0
			: $signed({1'b0, raw_center_q}) - $signed({1'b0, snap_q[drain_idx_q]});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drain_busy_q <= 1'b0;
			drain_bad_q  <= 1'b0;
			drain_idx_q  <= '0;
		end else if (work && at_end && !sample.frame_start) begin
			drain_busy_q <= 1'b1;
			drain_bad_q  <= frame_bad_final;
			drain_idx_q  <= '0;
		end else if (drain_busy_q && req_ready) begin
			if (req.last) begin
				drain_busy_q <= 1'b0;
			end
			drain_idx_q <= drain_idx_q + 1'b1;
		end
	end

	sbfd_scaler u_scaler (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale_gain (scale_gain_q),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req        (req),
		.result     (result)
	);

	// A frame never completes while the previous frame's results are still being issued.
	a_no_end_while_draining: assert property (@(posedge clk) disable iff (!arst_n)
		!(work && at_end && !sample.frame_start && drain_busy_q))
		else $error("frame completed while result sequencer busy");

	// The sequencer index stays inside the channel range.
	a_drain_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		drain_busy_q |-> ({1'b0, drain_idx_q} < (CIDX_W + 1)'(NUM_CHANNELS)))
		else $error("result sequencer index out of range");

	// A completed frame always starts the sequencer.
	a_end_starts_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(work && at_end && !sample.frame_start) |=> drain_busy_q)
		else $error("frame end did not start result sequencer");

	// A corrupted frame is reported as a single final request.
	a_bad_single: assert property (@(posedge clk) disable iff (!arst_n)
		(drain_busy_q && drain_bad_q) |-> (req.last && !req.ok))
		else $error("corrupted frame report not single");

endmodule
